// ===== rtl/lutf8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder package
// Widths and byte class constants shared by the decoder.
// ----------------------------------------------------------------------------
package lutf8_pkg;

  localparam int BYTE_W      = 8;
  localparam int CP_W        = 21;
  localparam int OUT_TDATA_W = ((CP_W + 7) / 8) * 8;
  localparam int REM_W       = 2;
  localparam int CONT_BITS   = 6;

  // Lead byte class limits.
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] TWO_LIMIT   = 8'hE0;
  localparam logic [BYTE_W-1:0] THREE_LIMIT = 8'hF0;

  // Continuation recognition and payload masks.
  localparam logic [BYTE_W-1:0] CONT_SEL  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;
  localparam logic [BYTE_W-1:0] TWO_MASK   = 8'h1F;
  localparam logic [BYTE_W-1:0] THREE_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] FOUR_MASK  = 8'h07;

  localparam logic [BYTE_W-1:0] END_BYTE = 8'h00;

  // Continuations still expected after each lead class.
  localparam logic [REM_W-1:0] REM_NONE  = 2'd0;
  localparam logic [REM_W-1:0] REM_TWO   = 2'd1;
  localparam logic [REM_W-1:0] REM_THREE = 2'd2;
  localparam logic [REM_W-1:0] REM_FOUR  = 2'd3;

endpackage

// ===== rtl/lenient_utf8_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder
// Decodes one text byte per transfer into code points and end-of-text marks.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] = text_byte
// m_axis    out        tdata[20:0] = code_point (upper bits zero), tlast = end_of_text
//
// One byte is accepted per cycle while m_axis is not stalled; a byte is registered,
// decoded in one step against the sequence state and its result, if any, lands in
// the output register, so a result passes through the input and output registers.
// The decode step advances whenever the output register is empty or being
// taken, so a stall on m_axis holds the input register and then s_axis.
// Synchronous reset clears the sequence state and both valid flags.
// ----------------------------------------------------------------------------
module lenient_utf8_decoder
  import lutf8_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] text_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [20:0] code_point, rest zero
  output logic                   m_axis_tlast    // end_of_text
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  logic              out_valid;
  logic [CP_W-1:0]   out_cp;
  logic              out_eot;

  logic [REM_W-1:0]  remaining;
  logic [CP_W-1:0]   acc;

  logic [REM_W-1:0]  remaining_next;
  logic [CP_W-1:0]   acc_next;
  logic              emit;
  logic [CP_W-1:0]   emit_cp;
  logic              emit_eot;
  logic [CP_W-1:0]   acc_shifted;
  logic              is_cont;
  logic              advance;
  logic              step;

  assign advance       = !out_valid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  assign is_cont     = (in_byte & CONT_SEL) == CONT_TAG;
  assign acc_shifted = {acc[CP_W-CONT_BITS-1:0], in_byte[CONT_BITS-1:0]};

  always_comb begin
    remaining_next = remaining;
    acc_next       = acc;
    emit           = 1'b0;
    emit_cp        = '0;
    emit_eot       = 1'b0;
    if (remaining != REM_NONE && is_cont) begin
      remaining_next = remaining - 1'b1;
      acc_next       = acc_shifted;
      if (remaining == REM_TWO) begin
        acc_next = '0;
        emit     = acc_shifted != '0;
        emit_cp  = acc_shifted;
      end
    end else begin
      // A non-continuation inside a sequence drops it and starts afresh.
      if (in_byte == END_BYTE) begin
        remaining_next = REM_NONE;
        acc_next       = '0;
        emit           = 1'b1;
        emit_eot       = 1'b1;
      end else if (in_byte < ASCII_LIMIT) begin
        remaining_next = REM_NONE;
        acc_next       = '0;
        emit           = 1'b1;
        emit_cp        = {{(CP_W-BYTE_W){1'b0}}, in_byte};
      end else if (in_byte < TWO_LIMIT) begin
        remaining_next = REM_TWO;
        acc_next       = {{(CP_W-BYTE_W){1'b0}}, in_byte & TWO_MASK};
      end else if (in_byte < THREE_LIMIT) begin
        remaining_next = REM_THREE;
        acc_next       = {{(CP_W-BYTE_W){1'b0}}, in_byte & THREE_MASK};
      end else begin
        remaining_next = REM_FOUR;
        acc_next       = {{(CP_W-BYTE_W){1'b0}}, in_byte & FOUR_MASK};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= REM_NONE;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        remaining <= remaining_next;
        acc       <= acc_next;
      end
      if (advance) begin
        out_valid <= step && emit;
      end
    end
    if (step && emit) begin
      out_cp  <= emit_cp;
      out_eot <= emit_eot;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-CP_W){1'b0}}, out_cp};
  assign m_axis_tlast  = out_eot;

  a_end_mark_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_eot |-> out_cp == '0)
    else $error("end mark carries a non-zero code point");

  a_cp_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_eot |-> out_cp != '0)
    else $error("zero code point delivered");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && in_byte == END_BYTE |=> remaining == REM_NONE && acc == '0)
    else $error("end of text left sequence state behind");

  a_idle_acc_clear: assert property (@(posedge clk) disable iff (rst)
    remaining == REM_NONE |-> acc == '0)
    else $error("accumulator holds bits with no sequence open");

  a_four_lead_bound: assert property (@(posedge clk) disable iff (rst)
    remaining == REM_FOUR |-> acc[CP_W-1:3] == '0)
    else $error("four-byte lead left too many accumulator bits");

endmodule
